### design/mfep_pkg.sv
// Package: word types, phase codes and constants for the MIDI file event parser.
`timescale 1ns / 1ps
package mfep_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  channel;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [31:0] tick;
    logic [15:0] track_index;
    logic [23:0] tempo_us;
    logic [15:0] file_format;
    logic [14:0] division;
    logic [15:0] track_count;
    logic [1:0]  error_code;
  } out_word_t;

  localparam logic [2:0] KIND_NOTE_OFF = 3'd0;
  localparam logic [2:0] KIND_NOTE_ON  = 3'd1;
  localparam logic [2:0] KIND_PROGRAM  = 3'd2;
  localparam logic [2:0] KIND_TEMPO    = 3'd3;
  localparam logic [2:0] KIND_HEADER   = 3'd4;
  localparam logic [2:0] KIND_ERROR    = 3'd5;
  localparam logic [2:0] KIND_DONE     = 3'd6;

  localparam logic [1:0] ERR_SMALL  = 2'd0;
  localparam logic [1:0] ERR_TAG    = 2'd1;
  localparam logic [1:0] ERR_LENGTH = 2'd2;
  localparam logic [1:0] ERR_SMPTE  = 2'd3;

  localparam logic [31:0] TAG_MTHD = 32'h4D54_6864;
  localparam logic [31:0] TAG_MTRK = 32'h4D54_726B;

  typedef enum logic [12:0] {
    PH_HDR    = 13'b0000000000001,
    PH_HSKIP  = 13'b0000000000010,
    PH_CHDR   = 13'b0000000000100,
    PH_IDLE   = 13'b0000000001000,
    PH_CSKIP  = 13'b0000000010000,
    PH_DELTA  = 13'b0000000100000,
    PH_STATUS = 13'b0000001000000,
    PH_D1     = 13'b0000010000000,
    PH_D2     = 13'b0000100000000,
    PH_MTYPE  = 13'b0001000000000,
    PH_MLEN   = 13'b0010000000000,
    PH_SXLEN  = 13'b0100000000000,
    PH_DSKIP  = 13'b1000000000000
  } phase_t;

endpackage

### design/mfep_out_queue.sv
// Output queue: four words deep, takes up to two words per byte, drains in order.
`timescale 1ns / 1ps
module mfep_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_count,
  input  mfep_pkg::out_word_t push_a,
  input  mfep_pkg::out_word_t push_b,
  output logic                room,
  output logic                valid,
  input  logic                ready,
  output mfep_pkg::out_word_t word
);
  import mfep_pkg::*;

  out_word_t  slot [4];
  logic [1:0] rd_ptr;
  logic [1:0] wr_ptr;
  logic [2:0] fill;
  logic       pop;

  assign pop   = valid && ready;
  assign valid = fill != 3'd0;
  assign word  = slot[rd_ptr];
  // room for two more words even if nothing drains this cycle
  assign room  = fill <= 3'd2;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) slot[wr_ptr] <= push_a;
    if (push_count == 2'd2) slot[wr_ptr + 2'd1] <= push_b;
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {1'b0, push_count} - {2'b0, pop};
    end
  end
endmodule

### design/midi_file_event_parser.sv
// Top level: Standard MIDI File byte parser producing note, program, tempo and header words.
//
// Usage: feed file bytes on in_valid/in_ready with payload in_word (data_byte,
// last_byte marks the final byte of a file). Result words leave on
// out_valid/out_ready as out_word: note off/on, program change, tempo,
// header, error, done. Each byte can cause up to
// two words (an event or header, then done on the last byte).
// With the queue empty, the first resulting word is offered in the next cycle.
// Throughput: one byte per cycle while the four-word output queue has room
// for two words; in_ready drops only when the queue holds three or more.
// A stalled receiver therefore backs up into in_ready after a few words.
// Reset clears the parse state to header collection and empties the queue.
// After the last byte of a file the parser returns to header collection on
// its own, so files may follow back to back.
`timescale 1ns / 1ps
module midi_file_event_parser (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  mfep_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output mfep_pkg::out_word_t out_word
);
  import mfep_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  header_count, header_count_next;
  logic [31:0] header_length, header_length_next;
  logic [47:0] header_fields, header_fields_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [31:0] skip_remaining, skip_remaining_next;
  logic [31:0] chunk_remaining, chunk_remaining_next;
  logic [15:0] chunks_left, chunks_left_next;
  logic [15:0] chunk_number, chunk_number_next;
  logic [31:0] track_tick, track_tick_next;
  logic [7:0]  running_status, running_status_next;
  logic [7:0]  current_status, current_status_next;
  logic [31:0] varlen_value, varlen_value_next;
  logic [2:0]  varlen_count, varlen_count_next;
  logic [7:0]  first_data, first_data_next;
  logic [7:0]  meta_kind, meta_kind_next;
  logic [23:0] tempo_accum, tempo_accum_next;
  logic        failed, failed_next;

  logic        accept;
  logic        room;
  logic [1:0]  push_count;
  out_word_t   push_a, push_b;
  logic [7:0]  b;
  logic [31:0] vl_new;
  logic [2:0]  vl_cnt_new;
  logic        vl_done;
  logic [7:0]  st;
  logic [7:0]  hi;
  phase_t      dphase;
  logic [31:0] cnt_dec;

  assign in_ready = room;
  assign accept   = in_valid && in_ready;
  assign b        = in_word.data_byte;
  assign vl_new     = {varlen_value[24:0], b[6:0]};
  assign vl_cnt_new = varlen_count + 3'd1;
  assign vl_done    = !b[7] || vl_cnt_new >= 3'd5;

  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    header_length_next   = header_length;
    header_fields_next   = header_fields;
    tag_shift_next       = tag_shift;
    skip_remaining_next  = skip_remaining;
    chunk_remaining_next = chunk_remaining;
    chunks_left_next     = chunks_left;
    chunk_number_next    = chunk_number;
    track_tick_next      = track_tick;
    running_status_next  = running_status;
    current_status_next  = current_status;
    varlen_value_next    = varlen_value;
    varlen_count_next    = varlen_count;
    first_data_next      = first_data;
    meta_kind_next       = meta_kind;
    tempo_accum_next     = tempo_accum;
    failed_next          = failed;
    push_count           = 2'd0;
    push_a               = '0;
    push_b               = '0;
    st                   = 8'd0;
    hi                   = 8'd0;
    dphase               = phase;
    cnt_dec              = chunk_remaining - 32'd1;

    if (accept && !failed) begin
      case (phase)
        PH_HDR: begin
          if (header_count < 4'd4) tag_shift_next = {tag_shift[23:0], b};
          else if (header_count < 4'd8) header_length_next = {header_length[23:0], b};
          else header_fields_next = {header_fields[39:0], b};
          header_count_next = header_count + 4'd1;
          if (header_count == 4'd13) begin
            push_count = 2'd1;
            if (tag_shift != TAG_MTHD || header_length < 32'd6 || header_fields[7]) begin
              push_a.kind = KIND_ERROR;
              if (tag_shift != TAG_MTHD) push_a.error_code = ERR_TAG;
              else if (header_length < 32'd6) push_a.error_code = ERR_LENGTH;
              else push_a.error_code = ERR_SMPTE;
              failed_next = 1'b1;
              phase_next  = PH_IDLE;
            end else begin
              push_a.kind        = KIND_HEADER;
              push_a.file_format = header_fields[39:24];
              push_a.track_count = header_fields[23:8];
              push_a.division    = {header_fields[6:0], b};
              chunks_left_next   = header_fields[23:8];
              chunk_number_next  = '0;
              skip_remaining_next = header_length - 32'd6;
              if (header_length != 32'd6) phase_next = PH_HSKIP;
              else if (header_fields[23:8] != 16'd0) begin
                phase_next = PH_CHDR;
                header_count_next = '0;
              end else phase_next = PH_IDLE;
            end
          end
        end
        PH_HSKIP: begin
          skip_remaining_next = skip_remaining - 32'd1;
          if (skip_remaining == 32'd1) begin
            if (chunks_left != 16'd0) begin
              phase_next = PH_CHDR;
              header_count_next = '0;
            end else phase_next = PH_IDLE;
          end
        end
        PH_CHDR: begin
          if (header_count < 4'd4) tag_shift_next = {tag_shift[23:0], b};
          else header_length_next = {header_length[23:0], b};
          header_count_next = header_count + 4'd1;
          if (header_count == 4'd7) begin
            chunks_left_next     = chunks_left - 16'd1;
            chunk_remaining_next = {header_length[23:0], b};
            if ({header_length[23:0], b} == 32'd0) begin
              chunk_number_next = chunk_number + 16'd1;
              if (chunks_left != 16'd1) begin
                phase_next = PH_CHDR;
                header_count_next = '0;
              end else phase_next = PH_IDLE;
            end else if (tag_shift == TAG_MTRK) begin
              track_tick_next     = '0;
              running_status_next = '0;
              current_status_next = '0;
              varlen_value_next   = '0;
              varlen_count_next   = '0;
              phase_next          = PH_DELTA;
            end else phase_next = PH_CSKIP;
          end
        end
        PH_IDLE: ;
        default: begin
          // track body
          dphase = phase;
          if (phase == PH_DELTA) begin
            varlen_value_next = vl_new;
            varlen_count_next = vl_cnt_new;
            if (vl_done) begin
              track_tick_next   = track_tick + vl_new;
              varlen_value_next = '0;
              varlen_count_next = '0;
              phase_next        = PH_STATUS;
            end
          end else if (phase == PH_STATUS) begin
            st = b[7] ? b : running_status;
            if (b[7]) running_status_next = b;
            current_status_next = st;
            if (st == 8'hFF) phase_next = PH_MTYPE;
            else if (st == 8'hF0 || st == 8'hF7) begin
              phase_next = PH_SXLEN;
              varlen_value_next = '0;
              varlen_count_next = '0;
            end else if (st[7] && st < 8'hF0) phase_next = PH_D1;
            else phase_next = PH_CSKIP;
            // running status: the byte is also the first data byte
            if (!b[7] && phase_next != PH_CSKIP) dphase = phase_next;
            else dphase = PH_IDLE;
          end
          if (phase != PH_DELTA && phase != PH_CSKIP && dphase != PH_IDLE) begin
            hi = (phase == PH_STATUS) ? (st & 8'hF0) : (current_status & 8'hF0);
            case (dphase)
              PH_D1: begin
                first_data_next = b;
                if (hi == 8'hC0) begin
                  push_count       = 2'd1;
                  push_a.kind      = KIND_PROGRAM;
                  push_a.channel   = (phase == PH_STATUS) ? st[3:0] : current_status[3:0];
                  push_a.data_one  = b;
                  push_a.tick      = track_tick;
                  push_a.track_index = chunk_number;
                  phase_next = PH_DELTA;
                end else if (hi == 8'hD0) phase_next = PH_DELTA;
                else phase_next = PH_D2;
              end
              PH_D2: begin
                if (hi == 8'h80 || hi == 8'h90) begin
                  push_count = 2'd1;
                  push_a.kind = (hi == 8'h90 && b != 8'd0) ? KIND_NOTE_ON : KIND_NOTE_OFF;
                  push_a.channel   = current_status[3:0];
                  push_a.data_one  = first_data;
                  push_a.data_two  = b;
                  push_a.tick      = track_tick;
                  push_a.track_index = chunk_number;
                end
                phase_next = PH_DELTA;
              end
              PH_MTYPE: begin
                meta_kind_next    = b;
                varlen_value_next = '0;
                varlen_count_next = '0;
                phase_next        = PH_MLEN;
              end
              PH_MLEN, PH_SXLEN: begin
                varlen_value_next = vl_new;
                varlen_count_next = vl_cnt_new;
                if (vl_done) begin
                  if (dphase == PH_SXLEN || vl_new < 32'd3) meta_kind_next = '0;
                  skip_remaining_next = vl_new;
                  varlen_value_next   = '0;
                  varlen_count_next   = '0;
                  tempo_accum_next    = '0;
                  phase_next = (vl_new == 32'd0) ? PH_DELTA : PH_DSKIP;
                end
              end
              PH_DSKIP: begin
                if (meta_kind == 8'h51 && varlen_count < 3'd3) begin
                  tempo_accum_next  = {tempo_accum[15:0], b};
                  varlen_count_next = vl_cnt_new;
                  if (vl_cnt_new == 3'd3) begin
                    push_count = 2'd1;
                    push_a.kind = KIND_TEMPO;
                    push_a.tick = track_tick;
                    push_a.track_index = chunk_number;
                    push_a.tempo_us = {tempo_accum[15:0], b};
                  end
                end
                skip_remaining_next = skip_remaining - 32'd1;
                if (skip_remaining == 32'd1) phase_next = PH_DELTA;
              end
              default: ;
            endcase
          end
          chunk_remaining_next = cnt_dec;
          if (cnt_dec == 32'd0) begin
            chunk_number_next = chunk_number + 16'd1;
            if (chunks_left != 16'd0) begin
              phase_next = PH_CHDR;
              header_count_next = '0;
            end else phase_next = PH_IDLE;
          end
        end
      endcase
    end

    if (accept && in_word.last_byte) begin
      if (!failed_next) begin
        if (push_count == 2'd0) begin
          push_count = 2'd1;
          push_a = '0;
          if (phase_next == PH_HDR) begin
            push_a.kind = KIND_ERROR;
            push_a.error_code = ERR_SMALL;
          end else push_a.kind = KIND_DONE;
        end else begin
          push_count = 2'd2;
          push_b = '0;
          push_b.kind = KIND_DONE;
        end
      end
      phase_next           = PH_HDR;
      header_count_next    = '0;
      header_length_next   = '0;
      header_fields_next   = '0;
      tag_shift_next       = '0;
      skip_remaining_next  = '0;
      chunk_remaining_next = '0;
      chunks_left_next     = '0;
      chunk_number_next    = '0;
      track_tick_next      = '0;
      running_status_next  = '0;
      current_status_next  = '0;
      varlen_value_next    = '0;
      varlen_count_next    = '0;
      first_data_next      = '0;
      meta_kind_next       = '0;
      tempo_accum_next     = '0;
      failed_next          = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HDR;
      header_count    <= '0;
      header_length   <= '0;
      header_fields   <= '0;
      tag_shift       <= '0;
      skip_remaining  <= '0;
      chunk_remaining <= '0;
      chunks_left     <= '0;
      chunk_number    <= '0;
      track_tick      <= '0;
      running_status  <= '0;
      current_status  <= '0;
      varlen_value    <= '0;
      varlen_count    <= '0;
      first_data      <= '0;
      meta_kind       <= '0;
      tempo_accum     <= '0;
      failed          <= 1'b0;
    end else begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      header_length   <= header_length_next;
      header_fields   <= header_fields_next;
      tag_shift       <= tag_shift_next;
      skip_remaining  <= skip_remaining_next;
      chunk_remaining <= chunk_remaining_next;
      chunks_left     <= chunks_left_next;
      chunk_number    <= chunk_number_next;
      track_tick      <= track_tick_next;
      running_status  <= running_status_next;
      current_status  <= current_status_next;
      varlen_value    <= varlen_value_next;
      varlen_count    <= varlen_count_next;
      first_data      <= first_data_next;
      meta_kind       <= meta_kind_next;
      tempo_accum     <= tempo_accum_next;
      failed          <= failed_next;
    end
  end

  mfep_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_a     (push_a),
    .push_b     (push_b),
    .room       (room),
    .valid      (out_valid),
    .ready      (out_ready),
    .word       (out_word)
  );

`ifndef SYNTHESIS
  a_onehot_phase: assert property (@(posedge clk) disable iff (rst) $onehot(phase))
    else $error("phase not one-hot");
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_word.last_byte |=> phase == PH_HDR && !failed)
    else $error("parser did not return to header after last word");
  a_failed_idle: assert property (@(posedge clk) disable iff (rst)
    failed |-> phase == PH_IDLE)
    else $error("failed outside idle");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> push_count == 2'd0)
    else $error("queue pushed while full");
`endif
endmodule

### test/tb.sv
// Testbench for the MIDI file event parser: byte-stream stimulus checked against a predictor.
`timescale 1ns / 1ps
module tb;
  import mfep_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  midi_file_event_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  always #5 clk = ~clk;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned files_sent = 0;
  int unsigned words_checked = 0;

  out_word_t   events_due[$];
  logic [7:0]  file_q[$];
  logic [7:0]  body_q[$];

  // parser state mirror
  phase_t      ph;
  int          hdr_cnt;
  logic [31:0] hdr_len;
  logic [47:0] hdr_fields;
  logic [31:0] tag_reg;
  logic [31:0] skip_left;
  logic [31:0] chunk_left_bytes;
  logic [15:0] chunks_todo;
  logic [15:0] chunk_num;
  logic [31:0] trk_tick;
  logic [7:0]  run_stat;
  logic [7:0]  cur_stat;
  logic [31:0] vl_val;
  int          vl_cnt;
  logic [7:0]  held_data;
  logic [7:0]  meta_sel;
  logic [23:0] tempo_acc;
  logic        parse_failed;

  function automatic void due_word(out_word_t w);
    events_due = {events_due, w};
  endfunction

  function automatic void file_byte(logic [7:0] v);
    file_q = {file_q, v};
  endfunction

  function automatic void body_byte(logic [7:0] v);
    body_q = {body_q, v};
  endfunction

  function automatic void parser_clear();
    ph = PH_HDR; hdr_cnt = 0; hdr_len = '0; hdr_fields = '0; tag_reg = '0;
    skip_left = '0; chunk_left_bytes = '0; chunks_todo = '0; chunk_num = '0;
    trk_tick = '0; run_stat = '0; cur_stat = '0; vl_val = '0; vl_cnt = 0;
    held_data = '0; meta_sel = '0; tempo_acc = '0; parse_failed = 1'b0;
  endfunction

  function automatic out_word_t blank(logic [2:0] k);
    out_word_t w;
    w = '0;
    w.kind = k;
    return w;
  endfunction

  function automatic void emit_chan(logic [2:0] k, logic [7:0] a, logic [7:0] b);
    out_word_t w;
    w = blank(k);
    w.channel = cur_stat[3:0];
    w.data_one = a;
    w.data_two = b;
    w.tick = trk_tick;
    w.track_index = chunk_num;
    due_word(w);
  endfunction

  function automatic void vl_clear();
    vl_val = '0;
    vl_cnt = 0;
  endfunction

  function automatic bit vl_take(logic [7:0] b);
    vl_val = {vl_val[24:0], b[6:0]};
    vl_cnt++;
    return !b[7] || vl_cnt >= 5;
  endfunction

  function automatic void next_chunk();
    if (chunks_todo > 0) begin
      ph = PH_CHDR;
      hdr_cnt = 0;
    end else begin
      ph = PH_IDLE;
    end
  endfunction

  function automatic void end_chunk();
    chunk_num++;
    next_chunk();
  endfunction

  function automatic void enter_status(logic [7:0] s);
    cur_stat = s;
    if (s == 8'hFF) begin
      ph = PH_MTYPE;
    end else if (s == 8'hF0 || s == 8'hF7) begin
      ph = PH_SXLEN;
      vl_clear();
    end else if (s >= 8'h80 && s < 8'hF0) begin
      ph = PH_D1;
    end else begin
      ph = PH_CSKIP;
    end
  endfunction

  function automatic void data_in(logic [7:0] b);
    logic [7:0] hi;
    out_word_t w;
    hi = cur_stat & 8'hF0;
    case (ph)
      PH_D1: begin
        held_data = b;
        if (hi == 8'hC0) begin
          emit_chan(KIND_PROGRAM, b, 8'd0);
          ph = PH_DELTA;
        end else if (hi == 8'hD0) begin
          ph = PH_DELTA;
        end else begin
          ph = PH_D2;
        end
      end
      PH_D2: begin
        if (hi == 8'h80) emit_chan(KIND_NOTE_OFF, held_data, b);
        else if (hi == 8'h90)
          emit_chan(b == 8'd0 ? KIND_NOTE_OFF : KIND_NOTE_ON, held_data, b);
        ph = PH_DELTA;
      end
      PH_MTYPE: begin
        meta_sel = b;
        vl_clear();
        ph = PH_MLEN;
      end
      PH_MLEN, PH_SXLEN: begin
        if (vl_take(b)) begin
          if (ph == PH_SXLEN || vl_val < 32'd3) meta_sel = '0;
          skip_left = vl_val;
          vl_clear();
          tempo_acc = '0;
          ph = (skip_left == 32'd0) ? PH_DELTA : PH_DSKIP;
        end
      end
      PH_DSKIP: begin
        if (meta_sel == 8'h51 && vl_cnt < 3) begin
          tempo_acc = {tempo_acc[15:0], b};
          vl_cnt++;
          if (vl_cnt == 3) begin
            w = blank(KIND_TEMPO);
            w.tick = trk_tick;
            w.track_index = chunk_num;
            w.tempo_us = tempo_acc;
            due_word(w);
          end
        end
        skip_left--;
        if (skip_left == 32'd0) ph = PH_DELTA;
      end
      default: ;
    endcase
  endfunction

  function automatic void track_in(logic [7:0] b);
    if (ph == PH_DELTA) begin
      if (vl_take(b)) begin
        trk_tick += vl_val;
        vl_clear();
        ph = PH_STATUS;
      end
    end else if (ph == PH_STATUS) begin
      if (b[7]) begin
        run_stat = b;
        enter_status(b);
      end else begin
        enter_status(run_stat);
        if (ph != PH_CSKIP) begin
          if (ph == PH_SXLEN) vl_clear();
          data_in(b);
        end
      end
    end else if (ph != PH_CSKIP) begin
      data_in(b);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic last);
    out_word_t w;
    logic [15:0] div;
    if (!parse_failed) begin
      case (ph)
        PH_HDR: begin
          if (hdr_cnt < 4) tag_reg = {tag_reg[23:0], b};
          else if (hdr_cnt < 8) hdr_len = {hdr_len[23:0], b};
          else hdr_fields = {hdr_fields[39:0], b};
          hdr_cnt++;
          if (hdr_cnt == 14) begin
            div = hdr_fields[15:0];
            w = blank(KIND_ERROR);
            if (tag_reg != TAG_MTHD) w.error_code = ERR_TAG;
            else if (hdr_len < 32'd6) w.error_code = ERR_LENGTH;
            else if (div[15]) w.error_code = ERR_SMPTE;
            else w.kind = KIND_HEADER;
            if (w.kind == KIND_ERROR) begin
              due_word(w);
              parse_failed = 1'b1;
              ph = PH_IDLE;
            end else begin
              w.file_format = hdr_fields[47:32];
              w.track_count = hdr_fields[31:16];
              w.division = div[14:0];
              due_word(w);
              chunks_todo = hdr_fields[31:16];
              chunk_num = '0;
              skip_left = hdr_len - 32'd6;
              if (skip_left > 32'd0) ph = PH_HSKIP;
              else next_chunk();
            end
          end
        end
        PH_HSKIP: begin
          skip_left--;
          if (skip_left == 32'd0) next_chunk();
        end
        PH_CHDR: begin
          if (hdr_cnt < 4) tag_reg = {tag_reg[23:0], b};
          else hdr_len = {hdr_len[23:0], b};
          hdr_cnt++;
          if (hdr_cnt == 8) begin
            chunks_todo--;
            chunk_left_bytes = hdr_len;
            if (chunk_left_bytes == 32'd0) begin
              end_chunk();
            end else if (tag_reg == TAG_MTRK) begin
              trk_tick = '0;
              run_stat = '0;
              cur_stat = '0;
              vl_clear();
              ph = PH_DELTA;
            end else begin
              ph = PH_CSKIP;
            end
          end
        end
        PH_IDLE: ;
        default: begin
          track_in(b);
          chunk_left_bytes--;
          if (chunk_left_bytes == 32'd0) end_chunk();
        end
      endcase
    end
    if (last) begin
      if (!parse_failed) begin
        w = (ph == PH_HDR) ? blank(KIND_ERROR) : blank(KIND_DONE);
        w.error_code = ERR_SMALL;
        due_word(w);
      end
      parser_clear();
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      errors++;
    end
  endfunction

  initial parser_clear();

  always @(posedge clk) begin
    out_word_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        words_checked++;
        if (events_due.size() == 0) begin
          $error("unexpected word: kind %0d", out_word.kind);
          errors++;
        end else begin
          e = events_due.pop_front();
          check_field("kind", 32'(e.kind), 32'(out_word.kind));
          check_field("channel", 32'(e.channel), 32'(out_word.channel));
          check_field("data_one", 32'(e.data_one), 32'(out_word.data_one));
          check_field("data_two", 32'(e.data_two), 32'(out_word.data_two));
          check_field("tick", e.tick, out_word.tick);
          check_field("track_index", 32'(e.track_index), 32'(out_word.track_index));
          check_field("tempo_us", 32'(e.tempo_us), 32'(out_word.tempo_us));
          check_field("file_format", 32'(e.file_format), 32'(out_word.file_format));
          check_field("division", 32'(e.division), 32'(out_word.division));
          check_field("track_count", 32'(e.track_count), 32'(out_word.track_count));
          check_field("error_code", 32'(e.error_code), 32'(out_word.error_code));
        end
      end
      if (in_valid && in_ready) predict_byte(in_word.data_byte, in_word.last_byte);
    end
  end

  always @(negedge clk)
    if (!rst) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic send_byte(logic [7:0] b, logic last);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_word <= '{data_byte: b, last_byte: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
    files_sent++;
  endtask

  function automatic void put32(logic [31:0] v);
    for (int i = 3; i >= 0; i--) file_byte(v[8*i +: 8]);
  endfunction

  function automatic void put_hdr(logic [31:0] tag, logic [31:0] len, logic [15:0] fmt,
                                  logic [15:0] cnt, logic [15:0] div);
    put32(tag);
    put32(len);
    put32({fmt, cnt});
    file_byte(div[15:8]);
    file_byte(div[7:0]);
    for (int i = 6; i < len && i < 12; i++) file_byte(8'($urandom_range(255)));
  endfunction

  function automatic void put_chunk(logic [31:0] tag, logic [31:0] len);
    put32(tag);
    put32(len);
    foreach (body_q[i]) file_byte(body_q[i]);
    body_q.delete();
  endfunction

  function automatic void put_vlq(logic [31:0] v);
    logic [7:0] grp[$];
    grp.push_front({1'b0, v[6:0]});
    v = v >> 7;
    while (v != 0) begin
      grp.push_front({1'b1, v[6:0]});
      v = v >> 7;
    end
    foreach (grp[i]) body_byte(grp[i]);
  endfunction

  function automatic void put_bytes(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    body_byte(a);
    body_byte(b);
    body_byte(c);
  endfunction

  function automatic void add_random_event();
    int unsigned r;
    logic [3:0] ch;
    ch = 4'($urandom_range(15));
    r = $urandom_range(99);
    if (r < 3) begin
      for (int i = 0; i < 5; i++) body_byte(8'($urandom_range(255)) | 8'h80);
    end else if (r < 70) begin
      put_vlq($urandom_range(127));
    end else begin
      put_vlq($urandom_range(32'h3F_FFFF));
    end
    r = $urandom_range(99);
    if (r < 25)
      put_bytes({4'h9, ch}, 8'($urandom_range(127)),
                ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(127)));
    else if (r < 35) put_bytes({4'h8, ch}, 8'($urandom_range(127)), 8'($urandom_range(127)));
    else if (r < 43) begin
      body_byte({4'hC, ch});
      body_byte(8'($urandom_range(127)));
    end else if (r < 48) begin
      body_byte({4'hD, ch});
      body_byte(8'($urandom_range(127)));
    end else if (r < 56) begin
      body_byte({4'hA + 4'($urandom_range(1)) * 4'h1, ch});
      if ($urandom_range(1)) body_q[$] = {4'hE, ch};
      body_byte(8'($urandom_range(127)));
      body_byte(8'($urandom_range(127)));
    end else if (r < 66) begin
      body_byte(8'($urandom_range(127)));
      if ($urandom_range(1)) body_byte(8'($urandom_range(127)));
    end else if (r < 78) begin
      int unsigned n;
      n = ($urandom_range(5) == 0) ? $urandom_range(4) : 3;
      body_byte(8'hFF);
      body_byte(8'h51);
      put_vlq(n);
      for (int i = 0; i < n; i++) body_byte(8'($urandom_range(255)));
    end else if (r < 92) begin
      int unsigned n;
      n = $urandom_range(4);
      if (r < 85) begin
        body_byte(8'hFF);
        body_byte(8'($urandom_range(127)));
      end else begin
        body_byte($urandom_range(1) ? 8'hF0 : 8'hF7);
      end
      put_vlq(n);
      for (int i = 0; i < n; i++) body_byte(8'($urandom_range(255)));
    end else if (r < 96) begin
      body_byte(8'hF1 + 8'($urandom_range(5)));
    end else begin
      body_byte(8'($urandom_range(255)));
    end
  endfunction

  task automatic test_header_checks();
    file_q = '{8'h4D, 8'h54, 8'h68, 8'h64, 8'h00};
    send_file();
    put_hdr(32'h4D54_6865, 32'd6, 16'd0, 16'd1, 16'd96);
    file_byte(8'hAA);
    send_file();
    put_hdr(TAG_MTHD, 32'd5, 16'd0, 16'd1, 16'd96);
    send_file();
    put_hdr(TAG_MTHD, 32'd6, 16'd0, 16'd1, 16'hE728);
    send_file();
    put_hdr(TAG_MTHD, 32'd6, 16'hFFFF, 16'h0000, 16'h7FFF);
    send_file();
    put_hdr(TAG_MTHD, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 16'h0000);
    send_file();
  endtask

  task automatic test_track_events();
    put_hdr(TAG_MTHD, 32'd8, 16'd1, 16'd3, 16'd480);
    put_vlq(0);   put_bytes(8'h93, 8'h3C, 8'h64);
    put_vlq(200); put_bytes(8'h3C, 8'h00, 8'h00);
    body_q.pop_back();
    put_vlq(5);   put_bytes(8'h8F, 8'hFF, 8'h80);
    put_vlq(0);   body_byte(8'hC2); body_byte(8'h7F);
    put_vlq(1);   body_byte(8'hD1); body_byte(8'h10);
    put_vlq(0);   put_bytes(8'hFF, 8'h51, 8'h03); put_bytes(8'h07, 8'hA1, 8'h20);
    put_vlq(0);   put_bytes(8'hFF, 8'h51, 8'h02); body_byte(8'h01);
    body_byte(8'h02);
    put_vlq(0);   put_bytes(8'hF0, 8'h02, 8'h11); body_byte(8'hF7);
    put_vlq(0);   body_byte(8'h05);
    put_bytes(8'hFF, 8'hFF, 8'hFF); body_byte(8'hFF); body_byte(8'h0F);
    put_vlq(0);   body_byte(8'hF4); body_byte(8'h00);
    put_chunk(TAG_MTRK, 32'(body_q.size()));
    put_vlq(0); body_byte(8'h40);
    put_chunk(TAG_MTRK, 32'(body_q.size()));
    put_vlq(0); put_bytes(8'h90, 8'h40, 8'h40);
    put_chunk(TAG_MTRK, 32'(body_q.size() - 1));
    send_file();
  endtask

  task automatic test_chunk_edges();
    put_hdr(TAG_MTHD, 32'd6, 16'd0, 16'd3, 16'd96);
    put_bytes(8'h01, 8'h02, 8'h03);
    put_chunk(32'h4D54_6864, 32'd3);
    put_chunk(TAG_MTRK, 32'd0);
    put_vlq(0); put_bytes(8'h9F, 8'h7F, 8'h7F);
    put_chunk(TAG_MTRK, 32'(body_q.size()));
    put_vlq(0); put_bytes(8'h90, 8'h01, 8'h01);
    put_chunk(TAG_MTRK, 32'(body_q.size()));
    send_file();
  endtask

  task automatic test_random_files(int unsigned n_bytes, int unsigned ipct, int unsigned spct);
    int unsigned goal;
    int unsigned r;
    int unsigned nchunks;
    int signed adj;
    idle_pct = ipct;
    stall_pct = spct;
    goal = bytes_sent + n_bytes;
    while (bytes_sent < goal) begin
      r = $urandom_range(99);
      if (r < 5) begin
        repeat ($urandom_range(30) + 1) file_byte(8'($urandom_range(255)));
      end else begin
        nchunks = $urandom_range(4);
        put_hdr((r < 7) ? 32'($urandom) : TAG_MTHD,
                (r < 9) ? 32'($urandom_range(5)) : ((r < 20) ? 32'($urandom_range(9, 6)) : 32'd6),
                16'($urandom_range(2)),
                (r < 15) ? 16'($urandom_range(5)) : 16'(nchunks),
                {(r < 12) ? 1'b1 : 1'b0, 15'($urandom)});
        for (int c = 0; c < nchunks; c++) begin
          repeat ($urandom_range(12, 1)) add_random_event();
          adj = ($urandom_range(9) == 0) ? int'($urandom_range(6)) - 3 : 0;
          if (int'(body_q.size()) + adj < 0) adj = 0;
          put_chunk(($urandom_range(6) == 0) ? 32'($urandom) : TAG_MTRK,
                    32'(int'(body_q.size()) + adj));
        end
        if ($urandom_range(3) == 0) file_byte(8'($urandom_range(255)));
      end
      send_file();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    out_ready <= 1'b1;
    @(negedge clk);
    test_header_checks();
    test_track_events();
    test_chunk_edges();
    test_random_files(360, 0, 0);
    test_random_files(360, 54, 0);
    test_random_files(360, 0, 54);
    test_random_files(360, 23, 23);
    in_valid <= 1'b0;
    wait (events_due.size() == 0);
    repeat (20) @(posedge clk);
    if (events_due.size() != 0) begin
      $error("%0d expected words never arrived", events_due.size());
      errors++;
    end
    $display("tb: %0d files, %0d bytes, %0d words checked, %0d mismatches",
             files_sent, bytes_sent, words_checked, errors);
    $display("tb: headers, errors, notes, programs, tempo, sysex, chunk skips, idle phases");
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule
